// ===== hdl/dif_pkg.sv =====
package dif_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned NXT_W   = 36;

  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TRAIL  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REJECT = 3'd4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic        is_integer;
    logic [31:0] value;
  } dif_result_t;

endpackage

// ===== hdl/decimal_integer_field_checker.sv =====
// A terminating zero word passes the input register s1, then the result register.
// Throughput: one text word per cycle while in_stall_o is low.
// A result waiting under out_stall_i holds only a terminating word; other words keep flowing.
// Reset (rst_ni low, asynchronous) empties the input and result registers and
// returns the scan to the leading white space phase.
module decimal_integer_field_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         text_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_integer_o,
  output logic signed [31:0] parsed_value_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_zero;
  logic                 s1_take;
  logic                 out_free;
  logic                 in_acc;
  logic                 out_valid_q;
  logic                 is_int_q;
  logic [31:0]          value_q;
  dif_pkg::dif_result_t res;

  assign s1_zero    = (s1_byte_q == dif_pkg::CHAR_NUL);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_take    = s1_valid_q && (!s1_zero || out_free);
  assign in_stall_o = s1_valid_q && !s1_take;
  assign in_acc     = in_valid_i && !in_stall_o;

  dif_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_take),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= text_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take && s1_zero) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && s1_zero) begin
      is_int_q <= res.is_integer;
      value_q  <= res.value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_integer_o   = is_int_q;
  assign parsed_value_o = value_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_zero && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_integer_o |-> parsed_value_o == 32'sd0)
    else $error("invalid field with nonzero value");

  a_result_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_take && s1_zero))
    else $error("result raised without a terminating word");

endmodule

// ===== hdl/dif_scan.sv =====
module dif_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output dif_pkg::dif_result_t res_o
);

  logic [dif_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                        neg_q, neg_d;
  logic [dif_pkg::MAG_W-1:0]   mag_q, mag_d;
  logic                        ovf_q, ovf_d;

  logic                        is_zero;
  logic                        is_digit;
  logic                        is_space;
  logic [dif_pkg::NXT_W-1:0]   mag_ext;
  logic [dif_pkg::NXT_W-1:0]   nxt;
  logic [dif_pkg::MAG_W-1:0]   dig_mag;
  logic                        dig_ovf;
  logic                        ok;

  assign is_zero  = (byte_i == dif_pkg::CHAR_NUL);
  assign is_digit = byte_i inside {[dif_pkg::CHAR_ZERO:dif_pkg::CHAR_NINE]};
  assign is_space = byte_i inside {dif_pkg::CHAR_SPACE, [dif_pkg::CHAR_TAB:dif_pkg::CHAR_CR]};

  assign mag_ext = {{(dif_pkg::NXT_W-dif_pkg::MAG_W){1'b0}}, mag_q};
  assign nxt = (mag_ext << 3) + (mag_ext << 1)
             + {{(dif_pkg::NXT_W-4){1'b0}}, byte_i[3:0]};

  always_comb begin
    if (nxt > {{(dif_pkg::NXT_W-dif_pkg::MAG_W){1'b0}}, dif_pkg::MAG_LIMIT}) begin
      dig_ovf = 1'b1;
      dig_mag = dif_pkg::MAG_LIMIT;
    end else begin
      dig_ovf = ovf_q;
      dig_mag = nxt[dif_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    ok = ((phase_q == dif_pkg::PH_DIGITS) || (phase_q == dif_pkg::PH_TRAIL)) && !ovf_q;
    res_o.is_integer = 1'b0;
    res_o.value      = '0;
    if (ok) begin
      if (neg_q) begin
        res_o.is_integer = 1'b1;
        res_o.value      = 32'd0 - mag_q;
      end else if (!mag_q[dif_pkg::MAG_W-1]) begin
        res_o.is_integer = 1'b1;
        res_o.value      = mag_q;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    if (is_zero) begin
      phase_d = dif_pkg::PH_LEAD;
      neg_d   = 1'b0;
      mag_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      case (phase_q)
        dif_pkg::PH_LEAD: begin
          if (is_digit) begin
            mag_d   = dig_mag;
            ovf_d   = dig_ovf;
            phase_d = dif_pkg::PH_DIGITS;
          end else if (byte_i == dif_pkg::CHAR_PLUS || byte_i == dif_pkg::CHAR_MINUS) begin
            neg_d   = (byte_i == dif_pkg::CHAR_MINUS);
            phase_d = dif_pkg::PH_SIGN;
          end else if (!is_space) begin
            phase_d = dif_pkg::PH_REJECT;
          end
        end
        dif_pkg::PH_SIGN: begin
          if (is_digit) begin
            mag_d   = dig_mag;
            ovf_d   = dig_ovf;
            phase_d = dif_pkg::PH_DIGITS;
          end else begin
            phase_d = dif_pkg::PH_REJECT;
          end
        end
        dif_pkg::PH_DIGITS: begin
          if (is_digit) begin
            mag_d = dig_mag;
            ovf_d = dig_ovf;
          end else if (is_space || byte_i == dif_pkg::CHAR_COMMA) begin
            phase_d = dif_pkg::PH_TRAIL;
          end else begin
            phase_d = dif_pkg::PH_REJECT;
          end
        end
        dif_pkg::PH_TRAIL: begin
          if (!is_space) begin
            phase_d = dif_pkg::PH_REJECT;
          end
        end
        default: begin
          phase_d = dif_pkg::PH_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dif_pkg::PH_LEAD;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
    end
  end

  a_clear_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_zero |=> phase_q == dif_pkg::PH_LEAD && mag_q == '0 && !neg_q && !ovf_q)
    else $error("field state not cleared after terminator");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> mag_q == dif_pkg::MAG_LIMIT)
    else $error("overflow without saturated magnitude");

  a_mag_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= dif_pkg::MAG_LIMIT)
    else $error("magnitude beyond limit");

endmodule
